/* design/dda_line_rasterizer_macros.svh */
// Assertion macros shared by the line rasterizer RTL.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define DLR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define DLR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/dlr_pkg.sv */
// Shared types and constants of the line rasterizer.
`default_nettype none
package dlr_pkg;
	localparam int COORD_FRAC_BITS = 8;
	localparam int STEP_FRAC_BITS  = 16;
	localparam int ROOT_ITERS      = 29;
	localparam int DIV_ITERS       = 17;
	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic sq_first;
		logic sq_second;
		logic root_init;
		logic root_iter;
		logic div_init;
		logic div_iter;
		logic div_sel_y;
		logic div_store;
		logic finish;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic out_free;
		logic q_zero;
	} stat_t;
endpackage
`default_nettype wire

/* design/dlr_ctrl.sv */
// Controller state machine sequencing loads and steps.
`default_nettype none
module dlr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_mode,
	output logic               in_ready,
	input  wire dlr_pkg::stat_t stat,
	output dlr_pkg::cmd_t      cmd
);
	import dlr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQX  = 3'd1;
	localparam logic [2:0] ST_SQY  = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_DIVX = 3'd4;
	localparam logic [2:0] ST_DIVY = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	localparam logic [4:0] ROOT_LAST = 5'(ROOT_ITERS);
	localparam logic [4:0] DIV_LAST  = 5'(DIV_ITERS + 1);

	logic [2:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       fire;

	assign in_ready = (state_q == ST_IDLE) && stat.out_free;
	assign fire     = in_valid && in_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (fire && !in_mode) begin
					cmd.load = 1'b1;
					state_d  = ST_SQX;
				end else if (fire) begin
					cmd.step = 1'b1;
				end
			end
			ST_SQX: begin
				cmd.sq_first = 1'b1;
				state_d      = ST_SQY;
			end
			ST_SQY: begin
				cmd.sq_second = 1'b1;
				cnt_d         = '0;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_init = (cnt_q == '0);
				cmd.root_iter = (cnt_q != '0);
				if (cnt_q == ROOT_LAST) begin
					cnt_d   = '0;
					state_d = ST_DIVX;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_DIVX, ST_DIVY: begin
				cmd.div_sel_y = (state_q == ST_DIVY);
				cmd.div_init  = (cnt_q == '0);
				cmd.div_store = (cnt_q == DIV_LAST);
				cmd.div_iter  = (cnt_q != '0) && (cnt_q != DIV_LAST);
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = (state_q == ST_DIVX) ? ST_DIVY : ST_FIN;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end
endmodule
`default_nettype wire

/* design/dlr_datapath.sv */
// Datapath: line state, squares, square root, divider and output register.
`default_nettype none
module dlr_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dlr_pkg::cmd_t cmd,
	output dlr_pkg::stat_t     stat,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [12:0]   cfg_data,
	input  wire logic [103:0]  in_data,
	output logic [47:0]        out_data,
	output logic               out_pixel_valid,
	output logic               out_line_done,
	output logic               out_valid,
	input  wire logic          out_ready
);
	import dlr_pkg::*;

	localparam int POS_SHIFT = STEP_FRAC_BITS - COORD_FRAC_BITS;

	logic [12:0]        width_q, height_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic signed [17:0] step_x_q, step_y_q;
	logic [12:0]        steps_left_q;
	logic [23:0]        line_colour_q;
	logic signed [20:0] dx_q, dy_q;
	logic [41:0]        sq_q;
	logic [57:0]        rad_q;
	logic [30:0]        rem_q;
	logic [28:0]        root_q;
	logic [44:0]        div_r_q, dsh_q;
	logic [16:0]        quo_q;
	logic               sat_q, neg_q;
	logic [47:0]        out_data_q;
	logic               out_pv_q, out_ld_q, out_valid_q;

	logic signed [19:0] xs, ys, xe, ye;
	logic signed [20:0] mul_a;
	logic signed [41:0] prod;
	logic [32:0]        rem_next, trial;
	logic [21:0]        rc;
	logic [13:0]        steps_full;
	logic [20:0]        mag;
	logic [44:0]        numer;
	logic [16:0]        q_sat;
	logic signed [17:0] step_new;
	logic signed [31:0] pos_nx, pos_ny;
	logic               in_img;
	logic [12:0]        steps_dec;

	assign xs = in_data[19:0];
	assign ys = in_data[39:20];
	assign xe = in_data[59:40];
	assign ye = in_data[79:60];

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.q_zero   = (sq_q == '0);

	// Squares through one shared multiplier
	assign mul_a = cmd.sq_first ? dx_q : dy_q;
	assign prod  = mul_a * mul_a;

	// One root bit per cycle
	assign rem_next = {rem_q, rad_q[57:56]};
	assign trial    = {2'b00, root_q, 2'b01};

	// Ceiling of the length in whole pixels
	assign rc         = {1'b0, root_q[28:8]} + {21'd0, (rem_q != '0)};
	assign steps_full = 14'((rc + 22'd255) >> COORD_FRAC_BITS);

	// Divider operands
	assign mag   = cmd.div_sel_y ? (dy_q[20] ? 21'(-dy_q) : 21'(dy_q))
	                             : (dx_q[20] ? 21'(-dx_q) : 21'(dx_q));
	assign numer = {mag, 24'd0};
	assign q_sat = (sat_q || quo_q > 17'h10000) ? 17'h10000 : quo_q;
	assign step_new = neg_q ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});

	// Next position and bounds test
	assign pos_nx    = pos_x_q + 32'(step_x_q);
	assign pos_ny    = pos_y_q + 32'(step_y_q);
	assign steps_dec = steps_left_q - 13'd1;
	assign in_img    = !pos_nx[31] && !pos_ny[31]
	                && (pos_nx[31:28] == '0) && (pos_ny[31:28] == '0)
	                && ({1'b0, pos_nx[27:16]} < width_q)
	                && ({1'b0, pos_ny[27:16]} < height_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			step_x_q      <= '0;
			step_y_q      <= '0;
			steps_left_q  <= '0;
			line_colour_q <= '0;
		end else begin
			if (cmd.load) begin
				pos_x_q       <= 32'(xs) <<< POS_SHIFT;
				pos_y_q       <= 32'(ys) <<< POS_SHIFT;
				line_colour_q <= {in_data[87:80], in_data[95:88], in_data[103:96]};
			end
			if (cmd.step && steps_left_q != '0) begin
				pos_x_q      <= pos_nx;
				pos_y_q      <= pos_ny;
				steps_left_q <= steps_dec;
			end
			if (cmd.div_store && !cmd.div_sel_y) step_x_q <= step_new;
			if (cmd.div_store && cmd.div_sel_y)  step_y_q <= step_new;
			if (cmd.finish) begin
				if (stat.q_zero) begin
					step_x_q     <= '0;
					step_y_q     <= '0;
					steps_left_q <= '0;
				end else begin
					steps_left_q <= steps_full[12:0];
				end
			end
		end
	end

	// Deltas, squares, root and divider working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= 21'(xe) - 21'(xs);
			dy_q <= 21'(ye) - 21'(ys);
		end
		if (cmd.sq_first)  sq_q <= 42'(prod);
		if (cmd.sq_second) sq_q <= sq_q + 42'(prod);
		if (cmd.root_init) begin
			rad_q  <= {sq_q, 16'd0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_iter) begin
			rad_q <= {rad_q[55:0], 2'b00};
			if (rem_next >= trial) begin
				rem_q  <= 31'(rem_next - trial);
				root_q <= {root_q[27:0], 1'b1};
			end else begin
				rem_q  <= rem_next[30:0];
				root_q <= {root_q[27:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			div_r_q <= numer;
			dsh_q   <= {root_q, 16'd0};
			quo_q   <= '0;
			sat_q   <= {1'b0, numer} >= {root_q, 17'd0};
			neg_q   <= cmd.div_sel_y ? dy_q[20] : dx_q[20];
		end else if (cmd.div_iter) begin
			dsh_q <= dsh_q >> 1;
			if (div_r_q >= dsh_q) begin
				div_r_q <= div_r_q - dsh_q;
				quo_q   <= {quo_q[15:0], 1'b1};
			end else begin
				quo_q   <= {quo_q[15:0], 1'b0};
			end
		end
	end

	// Output register: load when a result is issued, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= '0;
			out_pv_q   <= 1'b0;
			out_ld_q   <= stat.q_zero || (steps_full[12:0] == '0);
		end else if (cmd.step) begin
			if (steps_left_q != '0 && in_img) begin
				out_data_q <= {line_colour_q[7:0], line_colour_q[15:8],
				               line_colour_q[23:16], pos_ny[27:16], pos_nx[27:16]};
				out_pv_q   <= 1'b1;
			end else begin
				out_data_q <= '0;
				out_pv_q   <= 1'b0;
			end
			out_ld_q <= (steps_left_q == '0) || (steps_dec == '0);
		end
	end

	assign out_data        = out_data_q;
	assign out_pixel_valid = out_pv_q;
	assign out_line_done   = out_ld_q;
	assign out_valid       = out_valid_q;
endmodule
`default_nettype wire

/* design/dda_line_rasterizer.sv */
// Top level of the unit-step DDA line rasterizer.
// Input stream: tuser is the item kind (0 load a segment, 1 take one step);
// tdata carries both endpoints (signed Q12.8) and three 8-bit colours.
// Output stream: one result per input item; tdata carries the pixel
// coordinates and colour, tuser marks a pixel write inside the image, and
// tlast is high when no steps of the current line remain.
// A step item is accepted in any cycle the output register is free or being
// emptied, and its result appears the next cycle: one pixel per cycle.
// A load item takes two squarings on the shared multiplier, the bit-serial
// square root and two restoring-divider runs for the x and y unit steps,
// then issues its result once the output register is free; input is not
// accepted meanwhile. Image size is set through the write port (index 0
// width, 1 height); the user must write it only while idle, which the block
// does not enforce. Reset returns the sizes to 640 by 480 and clears the line
// state, so steps give invalid results with tlast set until a line is loaded.
// When the receiver stalls, the result is held and no new item is taken.
`default_nettype none
module dda_line_rasterizer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// x_start, y_start, x_end, y_end, red, green, blue
	input  wire logic [103:0] s_axis_tdata,
	// mode
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// pixel_x, pixel_y, out_red, out_green, out_blue
	output logic [47:0]       m_axis_tdata,
	// pixel_valid
	output logic              m_axis_tuser,
	output logic              m_axis_tlast,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [12:0]  cfg_data
);
	import dlr_pkg::*;

	`include "dda_line_rasterizer_macros.svh"

	cmd_t  cmd;
	stat_t stat;

	dlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dlr_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_data         (s_axis_tdata),
		.out_data        (m_axis_tdata),
		.out_pixel_valid (m_axis_tuser),
		.out_line_done   (m_axis_tlast),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready)
	);

	// Ready only with room in the output register
	`DLR_ASSERT_SAME(a_ready_room, s_axis_tready, !m_axis_tvalid || m_axis_tready)
	// A load blocks input in the following cycle
	`DLR_ASSERT_NEXT(a_load_busy, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !s_axis_tready)
	// A step result is presented in the following cycle
	`DLR_ASSERT_NEXT(a_step_out, s_axis_tvalid && s_axis_tready && s_axis_tuser, m_axis_tvalid)
endmodule
`default_nettype wire
